/* hdl/cll_pkg.sv */
`timescale 1ns / 1ps
package cll_pkg;
  localparam int CAPACITY = 16;
  localparam int DATA_BITS = 32;
  localparam int SLOT_BITS = $clog2(CAPACITY);
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);
  localparam int ARG_BITS = 32;

  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_ERASE = 2'd1;
  localparam logic [1:0] OP_SHIFT = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture op and argument, start modulo
    logic mod_step;   // one restoring-division step
    logic walk_step;  // advance cursor one link
    logic exec;       // apply insert/erase/clear
    logic fetch;      // read cursor slot value
    logic finish;     // drive result strobe
  } cmd_t;

  typedef struct packed {
    logic mod_done;
    logic walk_done;
  } stat_t;
endpackage

/* hdl/cll_ctrl.sv */
`timescale 1ns / 1ps
module cll_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     op,
  output logic           busy,
  output cll_pkg::cmd_t  cmd,
  input  cll_pkg::stat_t stat
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MOD   = 6'b000010,
    S_WALK  = 6'b000100,
    S_EXEC  = 6'b001000,
    S_FETCH = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequence the item through its phases
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = (op == cll_pkg::OP_SHIFT) ? S_MOD : S_EXEC;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_done) state_next = S_WALK;
      end
      S_WALK: begin
        if (stat.walk_done) state_next = S_FETCH;
        else cmd.walk_step = 1'b1;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_next = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
endmodule

/* hdl/cll_datapath.sv */
`timescale 1ns / 1ps
module cll_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [1:0]                    op,
  input  logic [cll_pkg::ARG_BITS-1:0]  argument,
  input  cll_pkg::cmd_t                 cmd,
  output cll_pkg::stat_t                stat,
  output logic                          done,
  output logic [31:0]                   cursor_value,
  output logic                          cursor_valid,
  output logic [4:0]                    entry_count,
  output logic                          status
);
  localparam int CAP = cll_pkg::CAPACITY;
  localparam int SB = cll_pkg::SLOT_BITS;
  localparam int CB = cll_pkg::COUNT_BITS;
  localparam int AB = cll_pkg::ARG_BITS;
  localparam int DB = cll_pkg::DATA_BITS;

  logic [DB-1:0]      vals [CAP];
  cll_pkg::slot_t     nxt [CAP];
  cll_pkg::slot_t     prv [CAP];
  logic [CAP-1:0]     free_slots;
  cll_pkg::slot_t     cursor_slot;
  cll_pkg::count_t    held_count;

  logic [1:0]         op_q;
  logic [AB-1:0]      arg_q;
  logic [AB-1:0]      quot;
  logic [CB-1:0]      rem;
  logic [$clog2(AB+1)-1:0] bit_cnt;
  logic [CB-1:0]      steps;
  logic               stat_q;

  // lowest free slot
  cll_pkg::slot_t     free_idx;
  logic               any_free;
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = CAP - 1; i >= 0; i--) begin
      if (free_slots[i]) begin
        free_idx = SB'(i);
        any_free = 1'b1;
      end
    end
  end

  // restoring division step
  logic [CB:0] trial;
  assign trial = {rem, quot[AB-1]};
  logic [CB:0] trial_sub;
  assign trial_sub = trial - {1'b0, held_count};

  cll_pkg::slot_t prev_idx, next_idx;
  assign prev_idx = prv[cursor_slot];
  assign next_idx = nxt[cursor_slot];

  assign stat.mod_done = (bit_cnt == ($clog2(AB+1))'(1));
  assign stat.walk_done = (steps == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      free_slots <= '1;
      cursor_slot <= '0;
      held_count <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.load) begin
        op_q <= op;
        arg_q <= argument;
        rem <= '0;
        bit_cnt <= ($clog2(AB+1))'(AB);
        stat_q <= 1'b0;
        // negative count or empty ring: no move
        quot <= (op == cll_pkg::OP_SHIFT && (argument[AB-1] || held_count == '0)) ?
                '0 : argument;
      end
      if (cmd.mod_step) begin
        quot <= {quot[AB-2:0], 1'b0};
        bit_cnt <= bit_cnt - 1'b1;
        if (held_count != '0 && !trial_sub[CB]) begin
          rem <= trial_sub[CB-1:0];
          if (stat.mod_done) steps <= trial_sub[CB-1:0];
        end else begin
          rem <= trial[CB-1:0];
          if (stat.mod_done) steps <= (held_count == '0) ? '0 : trial[CB-1:0];
        end
      end
      if (cmd.walk_step) begin
        cursor_slot <= nxt[cursor_slot];
        steps <= steps - 1'b1;
      end
      if (cmd.exec) begin
        case (op_q)
          cll_pkg::OP_INSERT: begin
            if (!any_free) begin
              stat_q <= 1'b1;
            end else begin
              free_slots[free_idx] <= 1'b0;
              vals[free_idx] <= arg_q[DB-1:0];
              if (held_count == '0) begin
                nxt[free_idx] <= free_idx;
                prv[free_idx] <= free_idx;
              end else begin
                prv[free_idx] <= prev_idx;
                nxt[free_idx] <= cursor_slot;
                nxt[prev_idx] <= free_idx;
                prv[cursor_slot] <= free_idx;
              end
              cursor_slot <= free_idx;
              held_count <= held_count + 1'b1;
            end
          end
          cll_pkg::OP_ERASE: begin
            if (held_count != '0) begin
              free_slots[cursor_slot] <= 1'b1;
              held_count <= held_count - 1'b1;
              if (held_count == CB'(1)) begin
                cursor_slot <= '0;
              end else begin
                nxt[prev_idx] <= next_idx;
                prv[next_idx] <= prev_idx;
                cursor_slot <= next_idx;
              end
            end
          end
          cll_pkg::OP_CLEAR: begin
            free_slots <= '1;
            cursor_slot <= '0;
            held_count <= '0;
          end
          default: ;
        endcase
      end
      // register the result
      if (cmd.fetch) begin
        cursor_value <= (held_count != '0) ? 32'(vals[cursor_slot]) : '0;
        cursor_valid <= (held_count != '0);
        entry_count <= 5'(held_count);
        status <= stat_q;
      end
    end
  end
endmodule

/* hdl/circular_list_with_cursor_top.sv */
`timescale 1ns / 1ps
// channel  | handshake        | fields
// command  | start / busy     | op, argument
// result   | done (1 cycle)   | cursor_value, cursor_valid, entry_count, status
// Insert, erase, clear: the item passes the exec, fetch and done states, and done
// is registered; busy drops in the done cycle, so the next item can be taken then.
// Shift: a 32-step serial modulo by the entry count, then one link walked per
// cycle (at most CAPACITY-1); the walk state then sees the walk finish, and the
// fetch and done states follow before done is high.
// Reset is synchronous; the ring comes up empty with every slot free.
// The receiver cannot stall; done pulses for one cycle per item.
module circular_list_with_cursor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [31:0] argument,
  output logic        done,
  output logic [31:0] cursor_value,
  output logic        cursor_valid,
  output logic [4:0]  entry_count,
  output logic        status
);
  cll_pkg::cmd_t  cmd;
  cll_pkg::stat_t stat;

  cll_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .op(op), .busy(busy),
    .cmd(cmd), .stat(stat)
  );

  cll_datapath u_dp (
    .clk(clk), .rst(rst), .op(op), .argument(argument), .cmd(cmd),
    .stat(stat), .done(done), .cursor_value(cursor_value),
    .cursor_valid(cursor_valid), .entry_count(entry_count), .status(status)
  );
endmodule

/* hdl/cll_checker.sv */
`timescale 1ns / 1ps
module cll_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [31:0] cursor_value,
  input logic       cursor_valid,
  input logic [4:0] entry_count,
  input logic       status
);
  // accepted item makes the block busy
  a_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("not busy after accept");
  // rejected insert only with a full ring
  a_full: assert property (@(posedge clk) disable iff (rst)
    done && status |-> cursor_valid && entry_count == 5'd16) else $error("reject not full");
  // valid matches nonzero count
  a_valid: assert property (@(posedge clk) disable iff (rst)
    done |-> (cursor_valid == (entry_count != 5'd0))) else $error("valid mismatch");
  // empty ring reports zero value
  a_zero: assert property (@(posedge clk) disable iff (rst)
    done && !cursor_valid |-> cursor_value == 32'd0) else $error("value not zero");
  // count never exceeds capacity
  a_cap: assert property (@(posedge clk) disable iff (rst)
    done |-> entry_count <= 5'd16) else $error("count over capacity");
endmodule

bind circular_list_with_cursor_top cll_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .cursor_value(cursor_value), .cursor_valid(cursor_valid),
  .entry_count(entry_count), .status(status)
);
